// File: design/dss_pkg.sv
// Shared widths, defaults, controller states and command/status types.
`timescale 1ns / 1ps

package dss_pkg;

	localparam int WORD_W        = 6;
	localparam int PARENT_W      = 7;
	localparam int MAX_WORDS_DEF = 64;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_WSTART,
		ST_WCHK,
		ST_READ,
		ST_UPDATE,
		ST_EMIT_RD,
		ST_EMIT
	} dss_state_t;

	typedef struct packed {
		logic load;        // store the incoming word, or flag overflow
		logic clr_sentence;
		logic idx_clr;
		logic idx_inc;
		logic init_wr;     // set span of word idx to itself
		logic rd_idx;      // read all stores at word idx
		logic rd_anc;      // read all stores at current ancestor
		logic upd_wr;      // widen span of current ancestor
		logic walk_begin;  // ancestor = parent read, steps = 0
		logic walk_next;   // ancestor = parent read, steps + 1
	} dss_cmd_t;

	typedef struct packed {
		logic idx_last;    // idx is the last stored word
		logic p_ok;        // parent read ends no walk
		logic step_ok;     // one more walk step is allowed
	} dss_sts_t;

endpackage

// File: design/dss_ctrl.sv
// Controller state machine: load, span init, ancestor walks, span emission.
`timescale 1ns / 1ps

module dss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              last_word,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  dss_pkg::dss_sts_t sts,
	output dss_pkg::dss_cmd_t cmd
);
	import dss_pkg::*;

	dss_state_t state_q;
	dss_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_word) begin
						cmd.idx_clr = 1'b1;
						state_nx    = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_nx    = ST_WSTART;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_WSTART: begin
				cmd.rd_idx = 1'b1;
				state_nx   = ST_WCHK;
			end
			ST_WCHK: begin
				if (sts.p_ok) begin
					cmd.walk_begin = 1'b1;
					state_nx       = ST_READ;
				end else if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_nx    = ST_EMIT_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nx    = ST_WSTART;
				end
			end
			ST_READ: begin
				cmd.rd_anc = 1'b1;
				state_nx   = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.upd_wr = 1'b1;
				if (sts.p_ok && sts.step_ok) begin
					cmd.walk_next = 1'b1;
					state_nx      = ST_READ;
				end else if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_nx    = ST_EMIT_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nx    = ST_WSTART;
				end
			end
			ST_EMIT_RD: begin
				cmd.rd_idx = 1'b1;
				state_nx   = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (sts.idx_last) begin
						cmd.clr_sentence = 1'b1;
						state_nx         = ST_LOAD;
					end else begin
						cmd.idx_inc = 1'b1;
						state_nx    = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_nx = ST_LOAD;
			end
		endcase
	end

	// a walk step always widens the ancestor it just read
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_anc |=> cmd.upd_wr)
		else $error("ancestor read not followed by update");

	// the walk over words starts only after the span init sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WSTART) |-> ($past(state_q) == ST_INIT || $past(state_q) == ST_WCHK
			|| $past(state_q) == ST_UPDATE))
		else $error("walk entered from wrong state");

	// the last emitted span hands the block back to loading
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_sentence |=> (state_q == ST_LOAD))
		else $error("sentence clear without return to load");

endmodule

// File: design/dss_datapath.sv
// Datapath: parent/first/last stores, word count, walk registers, read data.
`timescale 1ns / 1ps

module dss_datapath #(
	parameter int MAX_WORDS = dss_pkg::MAX_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dss_pkg::PARENT_W-1:0]  parent_index,
	input  dss_pkg::dss_cmd_t             cmd,
	output dss_pkg::dss_sts_t             sts,
	output logic [dss_pkg::WORD_W-1:0]    word_position,
	output logic [dss_pkg::WORD_W-1:0]    span_first,
	output logic [dss_pkg::WORD_W-1:0]    span_last,
	output logic                          overflowed
);
	import dss_pkg::*;

	localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int CNT_W  = $clog2(MAX_WORDS + 1);

	logic [PARENT_W-1:0] parent_mem [MAX_WORDS];
	logic [ADDR_W-1:0]   first_mem  [MAX_WORDS];
	logic [ADDR_W-1:0]   last_mem   [MAX_WORDS];

	logic [CNT_W-1:0]    cnt_q;
	logic                ovf_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [ADDR_W-1:0]   anc_q;
	logic [CNT_W-1:0]    steps_q;
	logic [PARENT_W-1:0] parent_rd_q;
	logic [ADDR_W-1:0]   first_rd_q;
	logic [ADDR_W-1:0]   last_rd_q;

	logic                store_ok;
	logic [CNT_W-1:0]    idx_nx;
	logic [CNT_W-1:0]    steps_nx;
	logic [ADDR_W-1:0]   parent_addr;
	logic [ADDR_W-1:0]   rd_addr;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ADDR_W-1:0]   first_wd;
	logic [ADDR_W-1:0]   last_wd;

	assign store_ok    = (cnt_q < CNT_W'(MAX_WORDS));
	assign idx_nx      = CNT_W'(idx_q) + CNT_W'(1);
	assign steps_nx    = steps_q + CNT_W'(1);
	assign parent_addr = parent_rd_q[ADDR_W-1:0];

	// parent ends the walk when negative or not below the word count
	assign sts.p_ok     = !parent_rd_q[PARENT_W-1]
		&& ({1'b0, parent_rd_q[PARENT_W-2:0]} < PARENT_W'(cnt_q));
	assign sts.idx_last = (idx_nx == cnt_q);
	assign sts.step_ok  = (steps_nx < cnt_q);

	assign rd_addr = cmd.rd_anc ? anc_q : idx_q;
	assign wr_en   = cmd.init_wr || cmd.upd_wr;
	assign wr_addr = cmd.upd_wr ? anc_q : idx_q;

	always_comb begin
		if (cmd.upd_wr) begin
			first_wd = (idx_q < first_rd_q) ? idx_q : first_rd_q;
			last_wd  = (idx_q > last_rd_q) ? idx_q : last_rd_q;
		end else begin
			first_wd = idx_q;
			last_wd  = idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
			anc_q   <= '0;
			steps_q <= '0;
		end else begin
			if (cmd.clr_sentence) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.load) begin
				if (store_ok) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_nx[ADDR_W-1:0];
			end
			if (cmd.walk_begin) begin
				anc_q   <= parent_addr;
				steps_q <= '0;
			end else if (cmd.walk_next) begin
				anc_q   <= parent_addr;
				steps_q <= steps_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && store_ok) begin
			parent_mem[cnt_q[ADDR_W-1:0]] <= parent_index;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			first_mem[wr_addr] <= first_wd;
			last_mem[wr_addr]  <= last_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_idx || cmd.rd_anc) begin
			parent_rd_q <= parent_mem[rd_addr];
			first_rd_q  <= first_mem[rd_addr];
			last_rd_q   <= last_mem[rd_addr];
		end
	end

	assign word_position = WORD_W'(idx_q);
	assign span_first    = WORD_W'(first_rd_q);
	assign span_last     = WORD_W'(last_rd_q);
	assign overflowed    = ovf_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_WORDS))
		else $error("word count beyond store depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_wr |-> (CNT_W'(anc_q) < cnt_q))
		else $error("span update outside the stored words");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.init_wr || cmd.rd_idx) |-> (CNT_W'(idx_q) < cnt_q))
		else $error("word index outside the stored words");

endmodule

// File: design/dependency_subtree_span.sv
// Top level: subtree span builder for one dependency tree at a time.
//
//  channel | direction | beat payload                                        | handshake
//  --------+-----------+-----------------------------------------------------+---------------------
//  in      | input     | parent_index, last_word                             | in_valid / in_stall
//  out     | output    | word_position, span_first, span_last, overflowed,   | out_valid / out_stall
//          |           | final_span                                          |
//
//  Steps: after the last word an init sweep sets each stored word's span to
//    itself, each word's ancestor walk reads its parent and then alternates
//    an ancestor read with a span update, and each span beat is a store
//    read, then present.
//  Reset: arst_n clears the controller, word count and overflow flag; the
//    stores are not cleared, only entries written in the current sentence
//    are read.
//  Stalls: in_stall is high from the last word until the final span beat is
//    taken; out_stall holds the presented span in place.
`timescale 1ns / 1ps

module dependency_subtree_span #(
	parameter int MAX_WORDS = dss_pkg::MAX_WORDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [dss_pkg::PARENT_W-1:0] parent_index,
	input  logic                                last_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [dss_pkg::WORD_W-1:0]          word_position,
	output logic [dss_pkg::WORD_W-1:0]          span_first,
	output logic [dss_pkg::WORD_W-1:0]          span_last,
	output logic                                overflowed,
	output logic                                final_span
);
	import dss_pkg::*;

	dss_cmd_t cmd;
	dss_sts_t sts;

	// sequence load, init, walks and emission
	dss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_word (last_word),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// hold the tree and the spans; run the walk arithmetic
	dss_datapath #(
		.MAX_WORDS (MAX_WORDS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.parent_index  (parent_index),
		.cmd           (cmd),
		.sts           (sts),
		.word_position (word_position),
		.span_first    (span_first),
		.span_last     (span_last),
		.overflowed    (overflowed)
	);

	// flag the span of the last stored word
	assign final_span = sts.idx_last;

	// a word's subtree always covers the word itself
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (span_first <= word_position && span_last >= word_position))
		else $error("span does not cover its own word");

	// after the final span beat, no further beat of that sentence
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && final_span) |=> !out_valid)
		else $error("beat after final span");

	// span beats come out in word order
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !final_span) |=> ##1
			(out_valid && word_position == $past(word_position, 2) + 6'd1))
		else $error("span beats out of order");

endmodule

// File: bench/dependency_subtree_span_test.sv
// Self-checking bench for dependency_subtree_span: random trees, stalls, span checks.
`timescale 1ns / 1ps

module dependency_subtree_span_test;
	import dss_pkg::*;

	// Run length guard: sized well past a run full of cyclic 64-word sentences.
	localparam int CYCLE_LIMIT = 600000;
	localparam int REPORT_MAX  = 10;
	localparam logic signed [PARENT_W-1:0] ROOT_HEAD = -7'sd1;

	// One input beat as queued for the driver; hold makes the driver wait
	// until every predicted span has drained before offering it.
	typedef struct {
		logic signed [PARENT_W-1:0] head;
		logic                       tail;
		bit                         hold;
	} word_beat_t;

	// One predicted span beat.
	typedef struct packed {
		logic [WORD_W-1:0] pos;
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] hi;
		logic              ovf;
		logic              fin;
	} span_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [PARENT_W-1:0] parent_index = '0;
	logic                       last_word = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [WORD_W-1:0]          word_position;
	logic [WORD_W-1:0]          span_first;
	logic [WORD_W-1:0]          span_last;
	logic                       overflowed;
	logic                       final_span;

	dependency_subtree_span dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.parent_index (parent_index),
		.last_word    (last_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.word_position(word_position),
		.span_first   (span_first),
		.span_last    (span_last),
		.overflowed   (overflowed),
		.final_span   (final_span)
	);

	word_beat_t pending[$];     // beats not yet offered to the block
	span_t      spans_due[$];   // spans predicted but not yet seen

	// Tree shadow: heads of the words stored so far in the open sentence.
	logic [PARENT_W-1:0] head_store [MAX_WORDS_DEF];
	int                  stored = 0;
	bit                  spilled = 1'b0;

	int faults = 0;
	int beats_sent = 0;
	int spans_seen = 0;
	int sentences_done = 0;
	int overflow_sentences = 0;
	int cycles = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	// Head of word w for the walk, or -1 where the walk stops: any negative
	// head, or a head at or past the number of stored words.
	function automatic int head_of(input int w);
		logic [PARENT_W-1:0] raw;
		raw = head_store[w];
		if (raw[PARENT_W-1])
			return -1;
		if (int'(raw) >= stored)
			return -1;
		return int'(raw);
	endfunction

	// Fold one accepted beat into the tree shadow. On the closing word,
	// build every subtree span and queue one expected beat per stored word.
	task automatic absorb_word(input logic signed [PARENT_W-1:0] head, input logic tail);
		int    lo [MAX_WORDS_DEF];
		int    hi [MAX_WORDS_DEF];
		int    w;
		int    a;
		int    steps;
		span_t s;
		if (stored < MAX_WORDS_DEF) begin
			head_store[stored] = head;
			stored++;
		end else begin
			spilled = 1'b1;
		end
		if (tail) begin
			for (w = 0; w < stored; w++) begin
				lo[w] = w;
				hi[w] = w;
			end
			// Widen each ancestor; the step bound stops cyclic chains.
			for (w = 0; w < stored; w++) begin
				steps = 0;
				a = head_of(w);
				while (a >= 0 && steps < stored) begin
					if (w < lo[a])
						lo[a] = w;
					if (w > hi[a])
						hi[a] = w;
					a = head_of(a);
					steps++;
				end
			end
			for (w = 0; w < stored; w++) begin
				s.pos = w[WORD_W-1:0];
				s.lo  = lo[w][WORD_W-1:0];
				s.hi  = hi[w][WORD_W-1:0];
				s.ovf = spilled;
				s.fin = (w == stored - 1);
				spans_due = {spans_due, s};
			end
			sentences_done++;
			if (spilled)
				overflow_sentences++;
			stored  = 0;
			spilled = 1'b0;
		end
	endtask

	task automatic add_beat(input logic signed [PARENT_W-1:0] head, input logic tail,
			input bit hold);
		word_beat_t b;
		b.head = head;
		b.tail = tail;
		b.hold = hold;
		pending = {pending, b};
	endtask

	// Queue one sentence of len words. A tidy sentence is a proper tree over
	// its first 64 words: shuffle the word order, make the first one the
	// root and hang each later one under a word picked earlier. Words past
	// the store keep random heads, and so does every word of an untidy one.
	task automatic queue_sentence(input int len, input bit tidy, input bit hold_first);
		int                  order[$];
		logic [PARENT_W-1:0] heads[$];
		logic [PARENT_W-1:0] h;
		int                  j;
		int                  k;
		int                  tmp;
		int                  span;
		span = (len > MAX_WORDS_DEF) ? MAX_WORDS_DEF : len;
		for (j = 0; j < len; j++) begin
			order = {order, j};
			h = PARENT_W'($urandom_range(127));
			heads = {heads, h};
		end
		if (tidy) begin
			for (j = span - 1; j > 0; j--) begin
				k = $urandom_range(j);
				tmp = order[j];
				order[j] = order[k];
				order[k] = tmp;
			end
			heads[order[0]] = ROOT_HEAD;
			for (j = 1; j < span; j++)
				heads[order[j]] = PARENT_W'(order[$urandom_range(j - 1)]);
		end
		for (j = 0; j < len; j++)
			add_beat(heads[j], j == len - 1, hold_first && j == 0);
	endtask

	// Driver: account for the beat taken at this edge, then offer the next
	// one unless idling, or unless the next beat waits for a full drain.
	always @(posedge clk) begin : feed
		word_beat_t b;
		bit         gap;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				absorb_word(parent_index, last_word);
				beats_sent++;
			end
			// Hold the beat while stalled; otherwise load the next one.
			if (!in_valid || !in_stall) begin
				// No idling across a long stretch in the middle of the run.
				gap = !(beats_sent >= 60 && beats_sent < 150) && ($urandom_range(99) < 7);
				if (pending.size() > 0 && !gap &&
						!(pending[0].hold && spans_due.size() > 0)) begin
					b = pending.pop_front();
					parent_index <= b.head;
					last_word    <= b.tail;
					in_valid     <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each span beat taken against the oldest prediction,
	// then pick the stall for the next cycle.
	always @(posedge clk) begin : watch
		span_t want;
		span_t seen;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				spans_seen++;
				seen = '{word_position, span_first, span_last, overflowed, final_span};
				if (spans_due.size() == 0) begin
					faults++;
					if (faults <= REPORT_MAX)
						$display("unexpected span beat: word %0d span %0d..%0d ovf %b fin %b",
							seen.pos, seen.lo, seen.hi, seen.ovf, seen.fin);
				end else begin
					want = spans_due.pop_front();
					if (seen !== want) begin
						faults++;
						if (faults <= REPORT_MAX)
							$display("span mismatch: expected word %0d span %0d..%0d",
								want.pos, want.lo, want.hi,
								" ovf %b fin %b,", want.ovf, want.fin,
								" got word %0d span %0d..%0d", seen.pos, seen.lo, seen.hi,
								" ovf %b fin %b", seen.ovf, seen.fin);
					end
				end
			end
			out_stall <= !(spans_seen >= 80 && spans_seen < 200) && ($urandom_range(99) < 7);
		end
	end

	// Watchdog: drop out of a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d spans outstanding",
				cycles, spans_due.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		int k;
		int len;
		int queued;
		// Directed trees. A lone root word.
		add_beat(ROOT_HEAD, 1'b1, 1'b0);
		// Two leaves under the root, a head past the count, a negative head
		// other than -1, and a word hanging under that cut-off word.
		add_beat(7'sd2, 1'b0, 1'b0);
		add_beat(7'sd2, 1'b0, 1'b0);
		add_beat(ROOT_HEAD, 1'b0, 1'b0);
		add_beat(7'sd63, 1'b0, 1'b0);
		add_beat(-7'sd64, 1'b0, 1'b0);
		add_beat(7'sd4, 1'b1, 1'b0);
		// Three-word cycle with no root: the step bound ends every walk.
		add_beat(7'sd1, 1'b0, 1'b0);
		add_beat(7'sd2, 1'b0, 1'b0);
		add_beat(7'sd0, 1'b1, 1'b0);
		// Word that heads itself.
		add_beat(7'sd0, 1'b0, 1'b0);
		add_beat(ROOT_HEAD, 1'b0, 1'b0);
		add_beat(7'sd1, 1'b1, 1'b0);
		// Chain down from the root, offered only once the block has drained.
		add_beat(ROOT_HEAD, 1'b0, 1'b1);
		add_beat(7'sd0, 1'b0, 1'b0);
		add_beat(7'sd1, 1'b0, 1'b0);
		add_beat(7'sd2, 1'b0, 1'b0);
		add_beat(7'sd3, 1'b0, 1'b0);
		add_beat(7'sd4, 1'b1, 1'b0);
		// Head past a short sentence's count.
		add_beat(7'sd5, 1'b0, 1'b0);
		add_beat(ROOT_HEAD, 1'b0, 1'b0);
		add_beat(7'sd1, 1'b1, 1'b0);

		// Random sentences: mostly proper trees with random shape, some
		// random heads. One fills the store exactly, one spills past it.
		queued = 0;
		k = 0;
		while (queued < 258) begin
			if (k == 3)
				len = MAX_WORDS_DEF;
			else if (k == 10)
				len = MAX_WORDS_DEF + 2;
			else
				len = $urandom_range(1, 10);
			queue_sentence(len, $urandom_range(99) < 80, k % 6 == 0);
			queued += len;
			k++;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: every beat offered and taken, every span seen.
		while (pending.size() > 0 || in_valid || spans_due.size() > 0)
			@(negedge clk);
		// Watch a little longer for stray span beats.
		repeat (64) @(negedge clk);

		$display("%0d words in %0d sentences, %0d of them past the store; %0d spans checked",
			beats_sent, sentences_done, overflow_sentences, spans_seen);
		$display("trees: roots, cycles, self heads, out-of-range and negative heads, up to %0d words",
			MAX_WORDS_DEF + 2);
		if (faults == 0 && spans_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d span faults", faults);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
